// ===== sv/dtle_pkg.sv =====
package dtle_pkg;

  typedef enum logic [1:0] {
    OP_UPSERT   = 2'd0,
    OP_SNAPSHOT = 2'd1,
    OP_MARK     = 2'd2,
    OP_COUNTS   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_UPDATED  = 3'd0,
    ST_INS_FREE = 3'd1,
    ST_INS_EVICT = 3'd2,
    ST_ENTRY    = 3'd3,
    ST_EMPTY    = 3'd4,
    ST_MARKED   = 3'd5,
    ST_NOT_MARKED = 3'd6,
    ST_COUNTS   = 3'd7
  } status_t;

  localparam logic [15:0] COUNT_SAT = 16'hFFFF;
  localparam logic [15:0] STALE_RESET = 16'd300;
  localparam int MAX_RESULTS = 16;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic scan_start;   // clear scan results and restart the scan index
    logic scan_step;    // examine the entry at the scan index
    logic write_upsert; // commit the upsert to the chosen slot
    logic write_mark;   // commit the mark to the matched slot
    logic load_result;  // load the output register
    logic hold_entry;   // hold the entry at the scan index for sending
    logic emit_entry;   // result is the held snapshot entry
    logic result_last;
  } dtle_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
    logic entry_qualifies;
    logic out_busy;
  } dtle_stat_t;

endpackage

// ===== sv/device_table_lru_evict.sv =====
// Device table with least-recently-seen eviction.
// Requests arrive on s_axis (tvalid/tready/tdata/tuser); tuser carries op.
// Results leave on m_axis with tlast on the final result of each request.
// Configuration: cfg_we writes the stale limit in seconds (reset 300).
// Every request walks all ENTRIES slots once, one slot per cycle, in a
// shared scan unit, except while a stalled receiver holds the snapshot
// scan; the next request is accepted only after the final result is loaded.
// Each qualifying snapshot entry is held for one step and sent when the next
// qualifying entry is found; a stalled receiver holds the scan there.
// The held entry left when the scan ends is sent as the final result, so it
// carries tlast and no extra result follows.
// Only one request is in work at a time; s_axis_tready rises again when the
// final result has been placed in the output register.
// Reset clears every table entry, the eviction count and the output valid flag.
module device_table_lru_evict
  import dtle_pkg::*;
#(
  parameter int ENTRIES = 16,
  parameter int PAYLOAD_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [15:0]  cfg_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // address[47:0], rssi[55:48], reading[87:56], now_s[119:88], seq[135:120],
  // entry_cap[140:136], zero fill to 144 bits.
  input  logic [143:0] s_axis_tdata,
  // op
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[2:0], address_res[50:3], rssi_res[58:51], reading_res[90:59],
  // entry_seq[106:91], last_seen_s[138:107], device_count[143:139],
  // evicted_count[159:144].
  output logic [159:0] m_axis_tdata,
  output logic         m_axis_tlast
);

  dtle_cmd_t  cmd, cmd_raw;
  dtle_stat_t stat;
  logic [2:0]  r_status;
  logic [47:0] r_address;
  logic [7:0]  r_rssi;
  logic [31:0] r_reading;
  logic [15:0] r_useq;
  logic [31:0] r_seen;
  logic [4:0]  r_dcount;
  logic [15:0] r_ecount;
  logic        r_last;
  logic        req_fire;

  assign req_fire = s_axis_tvalid && s_axis_tready;
  assign cmd = cmd_raw;

  dtle_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (s_axis_tvalid),
    .req_ready (s_axis_tready),
    .op_in     (s_axis_tuser),
    .stat      (stat),
    .cmd       (cmd_raw)
  );

  dtle_datapath #(
    .ENTRIES       (ENTRIES),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_data          (cfg_data),
    .req_fire          (req_fire),
    .req_op            (s_axis_tuser),
    .req_address       (s_axis_tdata[47:0]),
    .req_rssi          (s_axis_tdata[55:48]),
    .req_reading       (s_axis_tdata[87:56]),
    .req_now_s         (s_axis_tdata[119:88]),
    .req_seq           (s_axis_tdata[135:120]),
    .req_entry_cap     (s_axis_tdata[140:136]),
    .cmd               (cmd),
    .stat              (stat),
    .res_valid         (m_axis_tvalid),
    .res_ready         (m_axis_tready),
    .res_status        (r_status),
    .res_address       (r_address),
    .res_rssi          (r_rssi),
    .res_reading       (r_reading),
    .res_entry_seq     (r_useq),
    .res_last_seen_s   (r_seen),
    .res_last          (r_last),
    .res_device_count  (r_dcount),
    .res_evicted_count (r_ecount)
  );

  assign m_axis_tdata = {r_ecount, r_dcount, r_seen, r_useq, r_reading, r_rssi,
                         r_address, r_status};
  assign m_axis_tlast = r_last;

endmodule

// ===== sv/dtle_datapath.sv =====
module dtle_datapath
  import dtle_pkg::*;
#(
  parameter int ENTRIES = 16,
  parameter int PAYLOAD_WIDTH = 32,
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int CW = $clog2(ENTRIES + 1)
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [15:0]  cfg_data,
  input  logic         req_fire,
  input  logic [1:0]   req_op,
  input  logic [47:0]  req_address,
  input  logic [7:0]   req_rssi,
  input  logic [31:0]  req_reading,
  input  logic [31:0]  req_now_s,
  input  logic [15:0]  req_seq,
  input  logic [4:0]   req_entry_cap,
  input  dtle_cmd_t    cmd,
  output dtle_stat_t   stat,
  output logic         res_valid,
  input  logic         res_ready,
  output logic [2:0]   res_status,
  output logic [47:0]  res_address,
  output logic [7:0]   res_rssi,
  output logic [31:0]  res_reading,
  output logic [15:0]  res_entry_seq,
  output logic [31:0]  res_last_seen_s,
  output logic         res_last,
  output logic [4:0]   res_device_count,
  output logic [15:0]  res_evicted_count
);

  logic [ENTRIES-1:0]       valid_bits;
  logic [47:0]              addresses     [ENTRIES];
  logic [7:0]               signal_levels [ENTRIES];
  logic [PAYLOAD_WIDTH-1:0] payloads      [ENTRIES];
  logic [31:0]              seen_times    [ENTRIES];
  logic [15:0]              entry_seqs    [ENTRIES];
  logic [15:0]              reported_seqs [ENTRIES];
  logic [15:0]              evictions;
  logic [15:0]              stale_limit;

  logic [1:0]  op;
  logic [47:0] address;
  logic [7:0]  rssi;
  logic [31:0] reading;
  logic [31:0] now_s;
  logic [15:0] seq;
  logic [4:0]  limit;
  logic [4:0]  emitted;

  logic [CW-1:0] scan_idx;
  logic [IW-1:0] idx;
  logic          hit_found;
  logic [IW-1:0] hit_idx;
  logic          free_found;
  logic [IW-1:0] free_idx;
  logic [IW-1:0] old_idx;
  logic [IW-1:0] pend_idx;
  logic [CW-1:0] count;

  logic [31:0] age;
  logic        qualifies;
  logic        is_hit;

  assign idx = scan_idx[IW-1:0];
  assign age = now_s - seen_times[idx];
  assign is_hit = valid_bits[idx] && (addresses[idx] == address);
  assign qualifies = valid_bits[idx] && (age <= {16'd0, stale_limit})
                     && (entry_seqs[idx] != reported_seqs[idx]);

  assign stat.scan_done = (scan_idx == CW'(ENTRIES));
  assign stat.entry_qualifies = qualifies && (emitted < limit);
  assign stat.out_busy = res_valid && !res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stale_limit <= STALE_RESET;
    end else if (cfg_we) begin
      stale_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      op      <= req_op;
      address <= req_address;
      rssi    <= req_rssi;
      reading <= req_reading;
      now_s   <= req_now_s;
      seq     <= req_seq;
      limit   <= (req_entry_cap > 5'(MAX_RESULTS)) ? 5'(MAX_RESULTS) : req_entry_cap;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_idx   <= '0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
      old_idx    <= '0;
      count      <= '0;
      emitted    <= '0;
      hit_idx    <= '0;
      free_idx   <= '0;
      pend_idx   <= '0;
    end else if (cmd.scan_step) begin
      scan_idx <= scan_idx + 1'b1;
      if (valid_bits[idx]) begin
        count <= count + 1'b1;
      end
      if (is_hit && !hit_found) begin
        hit_found <= 1'b1;
        hit_idx   <= idx;
      end
      if (!valid_bits[idx] && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= idx;
      end
      if (seen_times[idx] < seen_times[old_idx]) begin
        old_idx <= idx;
      end
      if (cmd.hold_entry) begin
        emitted  <= emitted + 1'b1;
        pend_idx <= idx;
      end
    end
  end

  logic [IW-1:0] tgt;
  logic          claim;
  assign claim = !hit_found;
  assign tgt = hit_found ? hit_idx : (free_found ? free_idx : old_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
      evictions  <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        addresses[i]     <= '0;
        signal_levels[i] <= '0;
        payloads[i]      <= '0;
        seen_times[i]    <= '0;
        entry_seqs[i]    <= '0;
        reported_seqs[i] <= '0;
      end
    end else if (cmd.write_upsert) begin
      valid_bits[tgt]    <= 1'b1;
      signal_levels[tgt] <= rssi;
      payloads[tgt]      <= reading[PAYLOAD_WIDTH-1:0];
      seen_times[tgt]    <= now_s;
      if (claim) begin
        addresses[tgt]     <= address;
        entry_seqs[tgt]    <= 16'd1;
        reported_seqs[tgt] <= '0;
      end else begin
        entry_seqs[tgt] <= entry_seqs[tgt] + 16'd1;
      end
      if (claim && !free_found && evictions != COUNT_SAT) begin
        evictions <= evictions + 16'd1;
      end
    end else if (cmd.write_mark) begin
      if (hit_found && entry_seqs[hit_idx] == seq) begin
        reported_seqs[hit_idx] <= seq;
      end
    end
  end

  status_t st;
  always_comb begin
    unique case (op_t'(op))
      OP_UPSERT:   st = hit_found ? ST_UPDATED : (free_found ? ST_INS_FREE : ST_INS_EVICT);
      OP_SNAPSHOT: st = cmd.emit_entry ? ST_ENTRY : ST_EMPTY;
      OP_MARK:     st = (hit_found && entry_seqs[hit_idx] == seq) ? ST_MARKED : ST_NOT_MARKED;
      OP_COUNTS:   st = ST_COUNTS;
      default:     st = ST_EMPTY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.load_result) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  logic [PAYLOAD_WIDTH-1:0] pay;
  assign pay = payloads[pend_idx];

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      res_status        <= st;
      res_last          <= cmd.result_last;
      res_address       <= '0;
      res_rssi          <= '0;
      res_reading       <= '0;
      res_entry_seq     <= '0;
      res_last_seen_s   <= '0;
      res_device_count  <= '0;
      res_evicted_count <= '0;
      if (cmd.emit_entry) begin
        res_address     <= addresses[pend_idx];
        res_rssi        <= signal_levels[pend_idx];
        res_reading     <= 32'(pay);
        res_entry_seq   <= entry_seqs[pend_idx];
        res_last_seen_s <= seen_times[pend_idx];
      end
      if (op_t'(op) == OP_COUNTS) begin
        res_device_count  <= 5'(count);
        res_evicted_count <= evictions;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst && cmd.load_result) begin
      assert (!stat.out_busy) else $error("result overwritten while stalled");
    end
  end

  a_no_double: assert property (@(posedge clk) disable iff (rst)
    cmd.write_upsert |-> !cmd.write_mark) else $error("two writes at once");
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_step |-> scan_idx < CW'(ENTRIES)) else $error("scan past end");
  a_evict_sat: assert property (@(posedge clk) disable iff (rst)
    $past(evictions) == COUNT_SAT |-> evictions == COUNT_SAT)
    else $error("eviction count wrapped");

endmodule

// ===== sv/dtle_ctrl.sv =====
module dtle_ctrl
  import dtle_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  logic [1:0] op_in,
  input  dtle_stat_t stat,
  output dtle_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE, S_START, S_SCAN, S_FINISH
  } state_t;

  state_t     state;
  logic [1:0] op;
  logic       any;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    unique case (state)
      S_START: cmd.scan_start = 1'b1;
      S_SCAN: begin
        if (!stat.scan_done) begin
          if (op_t'(op) == OP_SNAPSHOT && stat.entry_qualifies) begin
            if (!any) begin
              cmd.scan_step  = 1'b1;
              cmd.hold_entry = 1'b1;
            end else if (!stat.out_busy) begin
              cmd.scan_step   = 1'b1;
              cmd.hold_entry  = 1'b1;
              cmd.emit_entry  = 1'b1;
              cmd.load_result = 1'b1;
            end
          end else begin
            cmd.scan_step = 1'b1;
          end
        end
      end
      S_FINISH: begin
        if (!stat.out_busy) begin
          cmd.load_result  = 1'b1;
          cmd.result_last  = 1'b1;
          cmd.emit_entry   = (op_t'(op) == OP_SNAPSHOT) && any;
          cmd.write_upsert = (op_t'(op) == OP_UPSERT);
          cmd.write_mark   = (op_t'(op) == OP_MARK);
        end
      end
      default: ;
    endcase
  end

  // Snapshot entries are held one step so the last one can carry tlast.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= '0;
      any   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (req_valid) begin
          op    <= op_in;
          any   <= 1'b0;
          state <= S_START;
        end
        S_START: state <= S_SCAN;
        S_SCAN: begin
          if (cmd.hold_entry) any <= 1'b1;
          if (stat.scan_done) state <= S_FINISH;
        end
        S_FINISH: if (!stat.out_busy) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  a_one_req: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready) else $error("second request taken");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_result |-> !stat.out_busy) else $error("load while stalled");
  a_step_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_step |-> state == S_SCAN) else $error("step outside scan");

endmodule

// ===== bench/tb_device_table_lru_evict.sv =====
`timescale 1ns / 100ps

module tb_device_table_lru_evict
  import dtle_pkg::*;
();

  localparam int SLOTS = 16;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    status_t     status;
    logic [47:0] address;
    logic [7:0]  rssi;
    logic [31:0] reading;
    logic [15:0] entry_seq;
    logic [31:0] last_seen;
    logic        last;
    logic [4:0]  device_count;
    logic [15:0] evicted_count;
  } result_t;

  typedef struct {
    op_t         op;
    logic [47:0] address;
    logic [7:0]  rssi;
    logic [31:0] reading;
    logic [31:0] now_s;
    logic [15:0] seq;
    logic [4:0]  entry_cap;
    logic        fixed;
    status_t     fixed_status;
  } request_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [15:0] cfg_data;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [143:0] s_axis_tdata;
  logic [1:0] s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [159:0] m_axis_tdata;
  logic m_axis_tlast;

  device_table_lru_evict u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  logic        tbl_valid [SLOTS];
  logic [47:0] tbl_addr [SLOTS];
  logic [7:0]  tbl_rssi [SLOTS];
  logic [31:0] tbl_reading [SLOTS];
  logic [31:0] tbl_seen [SLOTS];
  logic [15:0] tbl_useq [SLOTS];
  logic [15:0] tbl_rseq [SLOTS];
  logic [15:0] evict_total;
  logic [15:0] stale_limit;

  result_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic [47:0] known_addr[$];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int find_slot(logic [47:0] a);
    for (int i = 0; i < SLOTS; i++)
      if (tbl_valid[i] && tbl_addr[i] == a) return i;
    return -1;
  endfunction

  function automatic result_t blank_result(status_t s);
    result_t r;
    r = '0;
    r.status = s;
    r.last = 1'b1;
    return r;
  endfunction

  task automatic predict_table(input request_t q);
    int idx;
    int n;
    int lim;
    result_t r;
    status_t s;
    int cnt;
    case (q.op)
      OP_UPSERT: begin
        s = ST_UPDATED;
        idx = find_slot(q.address);
        if (idx < 0) begin
          s = ST_INS_FREE;
          for (int i = 0; i < SLOTS; i++)
            if (!tbl_valid[i] && idx < 0) idx = i;
          if (idx < 0) begin
            s = ST_INS_EVICT;
            idx = 0;
            for (int i = 1; i < SLOTS; i++)
              if (tbl_seen[i] < tbl_seen[idx]) idx = i;
            if (evict_total != COUNT_SAT) evict_total++;
          end
          tbl_addr[idx] = q.address;
          tbl_useq[idx] = '0;
          tbl_rseq[idx] = '0;
          tbl_valid[idx] = 1'b1;
        end
        tbl_useq[idx] = tbl_useq[idx] + 16'd1;
        tbl_rssi[idx] = q.rssi;
        tbl_reading[idx] = q.reading;
        tbl_seen[idx] = q.now_s;
        pending_results.push_back(blank_result(s));
      end
      OP_SNAPSHOT: begin
        lim = (q.entry_cap > MAX_RESULTS) ? MAX_RESULTS : q.entry_cap;
        n = 0;
        for (int i = 0; i < SLOTS && n < lim; i++) begin
          if (tbl_valid[i] && (q.now_s - tbl_seen[i]) <= {16'd0, stale_limit} &&
              tbl_useq[i] != tbl_rseq[i]) begin
            r = '0;
            r.status = ST_ENTRY;
            r.address = tbl_addr[i];
            r.rssi = tbl_rssi[i];
            r.reading = tbl_reading[i];
            r.entry_seq = tbl_useq[i];
            r.last_seen = tbl_seen[i];
            pending_results.push_back(r);
            n++;
          end
        end
        if (n == 0) pending_results.push_back(blank_result(ST_EMPTY));
        else pending_results[$].last = 1'b1;
      end
      OP_MARK: begin
        idx = find_slot(q.address);
        if (idx >= 0 && tbl_useq[idx] == q.seq) begin
          tbl_rseq[idx] = q.seq;
          pending_results.push_back(blank_result(ST_MARKED));
        end else begin
          pending_results.push_back(blank_result(ST_NOT_MARKED));
        end
      end
      default: begin
        cnt = 0;
        for (int i = 0; i < SLOTS; i++) if (tbl_valid[i]) cnt++;
        r = blank_result(ST_COUNTS);
        r.device_count = cnt[4:0];
        r.evicted_count = evict_total;
        pending_results.push_back(r);
      end
    endcase
  endtask

  function automatic request_t make_request(op_t op, logic [47:0] a, logic [31:0] now_s,
                                            logic [15:0] seq, logic [4:0] cap);
    request_t q;
    q.op = op;
    q.address = a;
    q.rssi = 8'($urandom);
    q.reading = $urandom;
    q.now_s = now_s;
    q.seq = seq;
    q.entry_cap = cap;
    q.fixed = 1'b0;
    q.fixed_status = ST_UPDATED;
    return q;
  endfunction

  task automatic send_request(input request_t q);
    predict_table(q);
    if (q.fixed && pending_results[$].status != q.fixed_status) begin
      $display("%0t: predicted status expected %0d actual %0d", $time,
               q.fixed_status, pending_results[$].status);
      errors++;
    end
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser = q.op;
    s_axis_tdata = {3'd0, q.entry_cap, q.seq, q.now_s, q.reading, q.rssi, q.address};
    while (!s_axis_tready) @(negedge clk);
    @(negedge clk);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic drain_results;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_stale_limit(logic [15:0] v);
    drain_results();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    stale_limit = v;
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t exp;
    cycles <= cycles + 1;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = result_t'({m_axis_tdata[2:0], m_axis_tdata[50:3], m_axis_tdata[58:51],
                       m_axis_tdata[90:59], m_axis_tdata[106:91], m_axis_tdata[138:107],
                       m_axis_tlast, m_axis_tdata[143:139], m_axis_tdata[159:144]});
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result expected none actual %h", $time, got);
        errors++;
      end else begin
        exp = pending_results.pop_front();
        if (got !== exp) begin
          $display("%0t: result expected %h actual %h", $time, exp, got);
          errors++;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("device_table_lru_evict: mismatch");
      $finish;
    end
  end

  always @(negedge clk)
    m_axis_tready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);

  function automatic logic [47:0] pick_addr();
    if (known_addr.size() == 0 || $urandom_range(3) == 0) begin
      known_addr.push_back(48'({$urandom, $urandom}));
      if (known_addr.size() > 24) void'(known_addr.pop_front());
      return known_addr[$];
    end
    return known_addr[$urandom_range(known_addr.size() - 1)];
  endfunction

  initial begin
    request_t directed[$];
    request_t q;
    int k;
    int op_pick;
    int idx;
    logic [31:0] clock_s;
    logic [47:0] a;
    for (int i = 0; i < SLOTS; i++) begin
      tbl_valid[i] = '0; tbl_addr[i] = '0; tbl_rssi[i] = '0; tbl_reading[i] = '0;
      tbl_seen[i] = '0; tbl_useq[i] = '0; tbl_rseq[i] = '0;
    end
    evict_total = '0;
    stale_limit = STALE_RESET;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b1;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    q = make_request(OP_COUNTS, 48'd0, 32'd0, 16'd0, 5'd0);
    q.fixed = 1'b1; q.fixed_status = ST_COUNTS; directed.push_back(q);
    q = make_request(OP_SNAPSHOT, 48'd0, 32'd0, 16'd0, 5'd16);
    q.fixed = 1'b1; q.fixed_status = ST_EMPTY; directed.push_back(q);
    q = make_request(OP_MARK, 48'd5, 32'd0, 16'd1, 5'd0);
    q.fixed = 1'b1; q.fixed_status = ST_NOT_MARKED; directed.push_back(q);
    q = make_request(OP_UPSERT, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 5'd31);
    q.rssi = 8'h80; q.reading = 32'hFFFF_FFFF;
    q.fixed = 1'b1; q.fixed_status = ST_INS_FREE; directed.push_back(q);
    q = make_request(OP_UPSERT, 48'hFFFF_FFFF_FFFF, 32'd10, 16'd0, 5'd0);
    q.rssi = 8'h7F; q.reading = 32'd0;
    q.fixed = 1'b1; q.fixed_status = ST_UPDATED; directed.push_back(q);
    q = make_request(OP_SNAPSHOT, 48'd0, 32'd10, 16'd0, 5'd0);
    q.fixed = 1'b1; q.fixed_status = ST_EMPTY; directed.push_back(q);
    directed.push_back(make_request(OP_SNAPSHOT, 48'd0, 32'd310, 16'd0, 5'd31));
    q = make_request(OP_SNAPSHOT, 48'd0, 32'd311, 16'd0, 5'd16);
    q.fixed = 1'b1; q.fixed_status = ST_EMPTY; directed.push_back(q);
    q = make_request(OP_MARK, 48'hFFFF_FFFF_FFFF, 32'd0, 16'd3, 5'd0);
    q.fixed = 1'b1; q.fixed_status = ST_NOT_MARKED; directed.push_back(q);
    q = make_request(OP_MARK, 48'hFFFF_FFFF_FFFF, 32'd0, 16'd2, 5'd0);
    q.fixed = 1'b1; q.fixed_status = ST_MARKED; directed.push_back(q);
    q = make_request(OP_SNAPSHOT, 48'd0, 32'd10, 16'd0, 5'd16);
    q.fixed = 1'b1; q.fixed_status = ST_EMPTY; directed.push_back(q);
    for (int i = 0; i < 16; i++)
      directed.push_back(make_request(OP_UPSERT, 48'd100 + 48'(i), 32'd20 + 32'(i),
                                      16'd0, 5'd0));
    foreach (directed[i]) send_request(directed[i]);
    q = make_request(OP_COUNTS, 48'd0, 32'd0, 16'd0, 5'd0);
    send_request(q);
    directed.delete();

    write_stale_limit(16'd0);
    send_request(make_request(OP_SNAPSHOT, 48'd0, 32'd35, 16'd0, 5'd16));
    send_request(make_request(OP_SNAPSHOT, 48'd0, 32'd20, 16'd0, 5'd16));
    write_stale_limit(16'hFFFF);
    send_request(make_request(OP_SNAPSHOT, 48'd0, 32'd40, 16'd0, 5'd16));

    clock_s = 32'd1000;
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 51 : 0;
      recv_idle_pct = (phase == 0) ? 51 : (phase == 1) ? 38 : 0;
      if (phase == 1) write_stale_limit(16'($urandom_range(20, 200)));
      if (phase == 2) write_stale_limit(STALE_RESET);
      for (int n = 0; n < 117; n++) begin
        clock_s = clock_s + 32'($urandom_range(0, 60));
        if ($urandom_range(19) == 0) clock_s = $urandom;
        op_pick = $urandom_range(99);
        if (op_pick < 50) begin
          q = make_request(OP_UPSERT, pick_addr(), clock_s, 16'($urandom), 5'($urandom));
        end else if (op_pick < 70) begin
          q = make_request(OP_SNAPSHOT, 48'($urandom), clock_s, 16'($urandom),
                           ($urandom_range(4) == 0) ? 5'($urandom_range(31)) : 5'd16);
        end else if (op_pick < 90) begin
          a = pick_addr();
          idx = find_slot(a);
          q = make_request(OP_MARK, a, $urandom, 16'($urandom), 5'($urandom));
          if (idx >= 0 && $urandom_range(3) != 0) q.seq = tbl_useq[idx];
        end else begin
          q = make_request(OP_COUNTS, 48'($urandom), $urandom, 16'($urandom),
                           5'($urandom));
        end
        send_request(q);
        if (n == 60) drain_results();
      end
    end

    k = 0;
    while (pending_results.size() != 0 && k < 100000) begin
      @(negedge clk);
      k++;
    end
    repeat (40) @(negedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("device_table_lru_evict: match");
    end else begin
      $display("device_table_lru_evict: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/dtle_pkg.sv
sv/dtle_datapath.sv
sv/dtle_ctrl.sv
sv/device_table_lru_evict.sv
bench/tb_device_table_lru_evict.sv
